// File: rtl/cvlt_pkg.sv
`timescale 1ns / 1ps
package cvlt_pkg;

    localparam int DEF_MAX_COLS  = 256;
    localparam int DEF_MAX_ROWS  = 256;
    localparam int DIST_W        = 9;
    localparam int COLOR_W       = 24;
    localparam int POS_W         = 8;
    localparam int CFG_W         = 9;
    // Wide enough for any coordinate, image size or register value.
    localparam int CMP_W         = 13;
    localparam logic [DIST_W-1:0] INFINITY_CODE = DIST_W'(257);

    // Mask step counter: five taps, then one write-back step.
    localparam logic [2:0] K_SELF = 3'd4;
    localparam logic [2:0] K_LAST = 3'd5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SEED  = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
    } offset_t;

    // Neighbor offsets of the forward (bwd = 0) and backward (bwd = 1) masks.
    function automatic offset_t mask_offset(input logic bwd, input logic [2:0] k);
        offset_t o;
        o = '{dx: 2'sd0, dy: 2'sd0};
        if (!bwd)
        begin
            case (k)
                3'd0: o = '{dx: -2'sd1, dy: -2'sd1};
                3'd1: o = '{dx: -2'sd1, dy:  2'sd0};
                3'd2: o = '{dx:  2'sd1, dy: -2'sd1};
                3'd3: o = '{dx:  2'sd0, dy: -2'sd1};
                default: o = '{dx: 2'sd0, dy: 2'sd0};
            endcase
        end
        else
        begin
            case (k)
                3'd0: o = '{dx:  2'sd0, dy: 2'sd1};
                3'd1: o = '{dx:  2'sd1, dy: 2'sd1};
                3'd2: o = '{dx:  2'sd1, dy: 2'sd0};
                3'd3: o = '{dx: -2'sd1, dy: 2'sd1};
                default: o = '{dx: 2'sd0, dy: 2'sd0};
            endcase
        end
        return o;
    endfunction

endpackage

// File: rtl/chamfer_voronoi_label_transform.sv
`timescale 1ns / 1ps
// Channel  | Handshake                      | Payload (lowest bit first)
// s_axis   | s_axis_tvalid / s_axis_tready  | tuser: op; tdata: pos_x, pos_y, seed_color
// m_axis   | m_axis_tvalid / m_axis_tready  | tuser: coord_error; tdata: pixel_color,
//          |                                |   pixel_distance, 7 zero bits
// cfg      | cfg_we (no wait)               | cfg_index, cfg_data
//
// Seed and read requests pass through the command, wait and done states; the registered
// read of the pixel memory sets the pace. Run steps each pixel in each of the two passes
// through five mask reads and one write-back. Clear sweeps the memory, one pixel a cycle,
// and the same sweep runs after reset before the first request is taken. A stalled result
// holds the block before it loads the next one; one further request may be taken
// meanwhile.
module chamfer_voronoi_label_transform
    import cvlt_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // pos_x, pos_y, seed_color
    input  logic [1:0]           s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // pixel_color, pixel_distance, zero pad
    output logic [0:0]           m_axis_tuser,   // coord_error
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int MW    = COLOR_W + DIST_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CMD   = 6'b000100,
        S_WAIT  = 6'b001000,
        S_RUN   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cols_reg, rows_reg;
    logic [CMP_W-1:0]     cols_eff, rows_eff;

    logic [MW-1:0]        mem [DEPTH];
    logic [MW-1:0]        mem_q_reg;
    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [MW-1:0]        wr_data;

    logic [AW:0]          clr_cnt_reg, clr_cnt_next;
    logic                 clr_report_reg, clr_report_next;
    op_t                  op_reg, op_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [COLOR_W-1:0]   seed_reg, seed_next;
    logic                 inside_reg, inside_next;

    logic                 pass_reg, pass_next;
    logic [CMP_W-1:0]     x_reg, x_next, y_reg, y_next;
    logic [2:0]           k_reg, k_next;
    logic [DIST_W-1:0]    best_reg, best_next;
    logic [COLOR_W-1:0]   bcol_reg, bcol_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic                 rd_w_reg, rd_w_next;

    logic [COLOR_W-1:0]   res_color_reg, res_color_next;
    logic [DIST_W-1:0]    res_dist_reg, res_dist_next;
    logic                 res_err_reg, res_err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic [DIST_W-1:0]    out_dist_reg, out_dist_next;
    logic                 out_err_reg, out_err_next;

    offset_t              ofs;
    logic [CMP_W-1:0]     nx, ny;
    logic                 nb_ok;
    logic [DIST_W-1:0]    q_dist, cand, best_new;
    logic [COLOR_W-1:0]   q_color, col_new;
    logic                 upd;
    logic [CMP_W-1:0]     in_x, in_y;
    logic                 in_inside;
    logic                 accept, load_out;

    assign cols_eff = (CMP_W'(cols_reg) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
                                                            : CMP_W'(cols_reg);
    assign rows_eff = (CMP_W'(rows_reg) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                            : CMP_W'(rows_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_x          = CMP_W'(s_axis_tdata[POS_W-1:0]);
    assign in_y          = CMP_W'(s_axis_tdata[2*POS_W-1:POS_W]);
    assign in_inside     = (in_x < cols_eff) && (in_y < rows_eff);

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {7'd0, out_dist_reg, out_color_reg};
    assign m_axis_tuser[0] = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(256);
            rows_reg <= CFG_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLS: cols_reg <= cfg_data;
                CFG_ROWS: rows_reg <= cfg_data;
                default:  cols_reg <= cols_reg;
            endcase
        end
    end

    // Pixel memory: {color, distance}, addressed {row, column}.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign q_dist  = mem_q_reg[DIST_W-1:0];
    assign q_color = mem_q_reg[MW-1:DIST_W];

    // Mask tap for the current step of the run sequencer.
    always_comb
    begin
        ofs   = mask_offset(pass_reg, k_reg);
        nx    = x_reg + {{(CMP_W-2){ofs.dx[1]}}, ofs.dx};
        ny    = y_reg + {{(CMP_W-2){ofs.dy[1]}}, ofs.dy};
        nb_ok = 1'b1;
        if (ofs.dx == -2'sd1 && x_reg == '0)
        begin
            nb_ok = 1'b0;
        end
        if (ofs.dx == 2'sd1 && nx >= cols_eff)
        begin
            nb_ok = 1'b0;
        end
        if (ofs.dy == -2'sd1 && y_reg == '0)
        begin
            nb_ok = 1'b0;
        end
        if (ofs.dy == 2'sd1 && ny >= rows_eff)
        begin
            nb_ok = 1'b0;
        end
    end

    // Relax against the tap read in the previous cycle; a tie goes to the later tap.
    always_comb
    begin
        if (!rd_w_reg)
        begin
            cand = q_dist;
        end
        else if (q_dist >= INFINITY_CODE - DIST_W'(1))
        begin
            cand = INFINITY_CODE;
        end
        else
        begin
            cand = q_dist + DIST_W'(1);
        end
        upd      = (k_reg != 3'd0) && rd_ok_reg && (cand <= best_reg);
        best_new = upd ? cand : best_reg;
        col_new  = upd ? q_color : bcol_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        seed_next       = seed_reg;
        inside_next     = inside_reg;
        pass_next       = pass_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        k_next          = k_reg;
        best_next       = best_reg;
        bcol_next       = bcol_reg;
        rd_ok_next      = 1'b0;
        rd_w_next       = 1'b0;
        res_color_next  = res_color_reg;
        res_dist_next   = res_dist_reg;
        res_err_next    = res_err_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = {seed_reg, DIST_W'(0)};
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        load_out        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg[AW-1:0];
                wr_data      = {COLOR_W'(0), INFINITY_CODE};
                clr_cnt_next = clr_cnt_reg + (AW+1)'(1);
                if (clr_cnt_reg[AW-1:0] == AW'(DEPTH - 1))
                begin
                    state_next = clr_report_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = op_t'(s_axis_tuser);
                    addr_next      = {in_y[YW-1:0], in_x[XW-1:0]};
                    seed_next      = s_axis_tdata[2*POS_W+COLOR_W-1:2*POS_W];
                    inside_next    = in_inside;
                    res_color_next = '0;
                    res_dist_next  = '0;
                    res_err_next   = 1'b0;
                    case (op_t'(s_axis_tuser))
                        OP_CLEAR:
                        begin
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        OP_RUN:
                        begin
                            pass_next = 1'b0;
                            x_next    = '0;
                            y_next    = '0;
                            k_next    = 3'd0;
                            best_next = INFINITY_CODE;
                            state_next = (cols_eff == '0 || rows_eff == '0) ? S_DONE
                                                                             : S_RUN;
                        end
                        default:
                        begin
                            res_err_next = !in_inside;
                            state_next   = S_CMD;
                        end
                    endcase
                end
            end
            S_CMD:
            begin
                wr_en      = (op_reg == OP_SEED) && inside_reg;
                rd_en      = (op_reg == OP_READ) && inside_reg;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (op_reg == OP_READ && inside_reg)
                begin
                    res_color_next = q_color;
                    res_dist_next  = q_dist;
                end
                state_next = S_DONE;
            end
            S_RUN:
            begin
                if (k_reg != K_LAST)
                begin
                    rd_en      = nb_ok;
                    rd_addr    = {ny[YW-1:0], nx[XW-1:0]};
                    rd_ok_next = nb_ok;
                    rd_w_next  = (k_reg != K_SELF);
                    best_next  = best_new;
                    bcol_next  = col_new;
                    k_next     = k_reg + 3'd1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = {y_reg[YW-1:0], x_reg[XW-1:0]};
                    wr_data   = {col_new, best_new};
                    best_next = INFINITY_CODE;
                    k_next    = 3'd0;
                    if (!pass_reg)
                    begin
                        if (x_reg + CMP_W'(1) < cols_eff)
                        begin
                            x_next = x_reg + CMP_W'(1);
                        end
                        else if (y_reg + CMP_W'(1) < rows_eff)
                        begin
                            x_next = '0;
                            y_next = y_reg + CMP_W'(1);
                        end
                        else
                        begin
                            pass_next = 1'b1;
                            x_next    = cols_eff - CMP_W'(1);
                            y_next    = rows_eff - CMP_W'(1);
                        end
                    end
                    else
                    begin
                        if (x_reg != '0)
                        begin
                            x_next = x_reg - CMP_W'(1);
                        end
                        else if (y_reg != '0)
                        begin
                            x_next = cols_eff - CMP_W'(1);
                            y_next = y_reg - CMP_W'(1);
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_color_next = out_color_reg;
        out_dist_next  = out_dist_reg;
        out_err_next   = out_err_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_color_next = res_color_reg;
            out_dist_next  = res_dist_reg;
            out_err_next   = res_err_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            k_reg          <= 3'd0;
            rd_ok_reg      <= 1'b0;
            rd_w_reg       <= 1'b0;
            pass_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            out_valid_reg  <= out_valid_next;
            k_reg          <= k_next;
            rd_ok_reg      <= rd_ok_next;
            rd_w_reg       <= rd_w_next;
            pass_reg       <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        seed_reg      <= seed_next;
        inside_reg    <= inside_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        best_reg      <= best_next;
        bcol_reg      <= bcol_next;
        res_color_reg <= res_color_next;
        res_dist_reg  <= res_dist_next;
        res_err_reg   <= res_err_next;
        out_color_reg <= out_color_next;
        out_dist_reg  <= out_dist_next;
        out_err_reg   <= out_err_next;
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> out_color_reg == '0 && out_dist_reg == '0)
        else $error("coord_error result carries nonzero payload");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_dist_reg <= INFINITY_CODE)
        else $error("distance above infinity code");

    a_run_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> x_reg < cols_eff && y_reg < rows_eff)
        else $error("run sequencer left the image");

    a_run_best: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN && k_reg == 3'd0 |-> best_reg == INFINITY_CODE)
        else $error("best distance not restarted for new pixel");

endmodule
